### hw/rtl/cobu_pkg.sv
// Shared types and constants for the consolidated order book update core.
package cobu_pkg;

	localparam int PRICE_W   = 32;
	localparam int QTY_W     = 32;
	localparam int TOTAL_W   = 35;
	localparam int VENUE_W   = 3;
	localparam int OUTCOME_W = 4;

	// venue_slot, price, new_qty packed from bit 0 and padded to bytes
	localparam int IN_RAW_W  = VENUE_W + PRICE_W + QTY_W;
	localparam int IN_DATA_W = ((IN_RAW_W + 7) / 8) * 8;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_ABSENT     = 4'd0,
		OUT_INSERTED   = 4'd1,
		OUT_ERASED     = 4'd2,
		OUT_UPDATED    = 4'd3,
		OUT_JOINED     = 4'd4,
		OUT_LEFT       = 4'd5,
		OUT_NO_VENUE   = 4'd6,
		OUT_VENUE_FULL = 4'd7,
		OUT_SIDE_FULL  = 4'd8
	} cobu_outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPARE,
		ST_DECIDE,
		ST_SHIFT,
		ST_MOVE,
		ST_WRITE,
		ST_DONE
	} cobu_state_t;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_WRITE,
		ACT_INSERT,
		ACT_ERASE
	} cobu_action_t;

endpackage

### hw/rtl/consolidated_order_book_update_core.sv
// Consolidated price-level order book: sorted bid/ask level tables held in one memory.
//
// Usage: one input word on s_axis is one venue quote change (side in tuser,
// venue, price and new quantity in tdata). Each word yields exactly one result
// word on m_axis: outcome, level index, level total, venue count and levels
// shifted. The block takes one word at a time; s_axis_tready is high only
// while it waits for work, and it may rise while a result still sits unclaimed
// in the output register.
// All levels of both sides live in one single-port-read, single-port-write
// memory, one row per level holding price, total, venue count and the whole
// venue share list. The binary search over the side's level count takes at
// most ceil(log2(count+1)) steps, each a memory read and a compare. An in-place
// update writes the level row once; an insert or erase first moves every level
// behind it by one row, each move a memory read followed by a write of the
// neighbouring row, and an insert then writes the new row. The next word can
// be taken in the cycle after the result is loaded.
// Reset clears both level counts and the control state; memory rows are not
// cleared, as no row past a level count is ever read.
// When the receiver stalls, the finished result holds in the output register;
// a following word is processed up to its result and then waits there.
module consolidated_order_book_update_core #(
	parameter int LEVEL_DEPTH = 2048,
	parameter int MAX_VENUES  = 8,
	localparam int IW      = $clog2(LEVEL_DEPTH + 1),
	localparam int VW      = $clog2(MAX_VENUES + 1),
	localparam int OUT_RAW = cobu_pkg::OUTCOME_W + IW + cobu_pkg::TOTAL_W + VW + IW,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// venue_slot[2:0], price[34:3], new_qty[66:35], zero pad
	input  logic [cobu_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// is_ask
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// outcome, level_index, level_total, level_venues, entries_shifted, zero pad
	output logic [OUT_W-1:0]               m_axis_tdata
);
	import cobu_pkg::*;

	localparam int AW     = $clog2(LEVEL_DEPTH);
	localparam int SIW    = (MAX_VENUES > 1) ? $clog2(MAX_VENUES) : 1;
	localparam int SH_W   = VENUE_W + QTY_W;
	localparam int TOT_LO = PRICE_W;
	localparam int NV_LO  = PRICE_W + TOTAL_W;
	localparam int SH_LO  = NV_LO + VW;
	localparam int ROW_W  = SH_LO + MAX_VENUES * SH_W;

	cobu_state_t  state_q, state_d;
	logic [ROW_W-1:0] mem [2**(AW+1)];
	logic [ROW_W-1:0] rdata_q;
	logic             mem_re, mem_we;
	logic [AW:0]      raddr, waddr;
	logic [ROW_W-1:0] wdata;

	logic [IW-1:0] cnt_bid_q, cnt_ask_q, cnt_q;
	logic [IW-1:0] lo_q, hi_q, ptr_q, mid;
	logic          side_q, row_ok_q;
	logic [VENUE_W-1:0] venue_q;
	logic [PRICE_W-1:0] price_q;
	logic [QTY_W-1:0]   qty_q;
	cobu_action_t  act_q, act_d;
	logic [ROW_W-1:0] new_row_q, new_row_d;

	cobu_outcome_t       res_outcome_q, res_outcome_d;
	logic [TOTAL_W-1:0]  res_total_q, res_total_d;
	logic [VW-1:0]       res_venues_q, res_venues_d;
	logic [IW-1:0]       res_shifted_q, res_shifted_d;
	logic                m_valid_q;
	logic [OUT_RAW-1:0]  m_data_q;

	logic accept, out_free, ahead, search_more, shift_done;
	logic [PRICE_W-1:0] rp;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign rp       = rdata_q[PRICE_W-1:0];
	assign ahead    = side_q ? (rp < price_q) : (rp > price_q);
	assign search_more = lo_q < hi_q;
	assign shift_done  = (act_q == ACT_INSERT) ? (ptr_q == lo_q) : ((ptr_q + 1'b1) >= cnt_q);

	// decide: work out the change to the level row found by the search
	logic               present, found;
	logic [VW-1:0]      nv, at, pos;
	logic [VENUE_W-1:0] sv [MAX_VENUES];
	logic [QTY_W-1:0]   sq [MAX_VENUES];
	logic [VENUE_W-1:0] nsv [MAX_VENUES];
	logic [QTY_W-1:0]   nsq [MAX_VENUES];
	logic [TOTAL_W-1:0] old_total, new_total;
	logic [VW-1:0]      new_nv;

	always_comb begin
		present   = row_ok_q && (rp == price_q);
		nv        = rdata_q[NV_LO +: VW];
		old_total = rdata_q[TOT_LO +: TOTAL_W];
		found     = 1'b0;
		at        = '0;
		pos       = '0;
		for (int i = 0; i < MAX_VENUES; i++) begin
			sv[i] = rdata_q[SH_LO + i*SH_W +: VENUE_W];
			sq[i] = rdata_q[SH_LO + i*SH_W + VENUE_W +: QTY_W];
		end
		for (int i = 0; i < MAX_VENUES; i++) begin
			if (!found && (VW'(i) < nv) && (sv[i] == venue_q)) begin
				found = 1'b1;
				at    = VW'(i);
			end
			if ((VW'(i) < nv) && (sv[i] < venue_q))
				pos = pos + 1'b1;
		end

		act_d         = ACT_NONE;
		res_outcome_d = OUT_ABSENT;
		res_total_d   = '0;
		res_venues_d  = '0;
		res_shifted_d = '0;
		new_total     = old_total;
		new_nv        = nv;
		for (int i = 0; i < MAX_VENUES; i++) begin
			nsv[i] = sv[i];
			nsq[i] = sq[i];
		end

		if (!present) begin
			if (qty_q == '0) begin
				res_outcome_d = OUT_ABSENT;
			end else if (cnt_q >= IW'(LEVEL_DEPTH)) begin
				res_outcome_d = OUT_SIDE_FULL;
			end else begin
				act_d         = ACT_INSERT;
				res_outcome_d = OUT_INSERTED;
				new_total     = TOTAL_W'(qty_q);
				new_nv        = VW'(1);
				for (int i = 0; i < MAX_VENUES; i++) begin
					nsv[i] = '0;
					nsq[i] = '0;
				end
				nsv[0]        = venue_q;
				nsq[0]        = qty_q;
				res_total_d   = new_total;
				res_venues_d  = new_nv;
				res_shifted_d = cnt_q - lo_q;
			end
		end else if (qty_q == '0) begin
			if (!found) begin
				res_outcome_d = OUT_NO_VENUE;
				res_total_d   = old_total;
				res_venues_d  = nv;
			end else begin
				new_total = old_total - TOTAL_W'(sq[at[SIW-1:0]]);
				new_nv    = nv - 1'b1;
				// close the gap left by the leaving venue
				for (int i = 0; i < MAX_VENUES - 1; i++) begin
					if (VW'(i) >= at) begin
						nsv[i] = sv[i+1];
						nsq[i] = sq[i+1];
					end
				end
				if (new_nv == '0) begin
					act_d         = ACT_ERASE;
					res_outcome_d = OUT_ERASED;
					res_shifted_d = cnt_q - lo_q - 1'b1;
				end else begin
					act_d         = ACT_WRITE;
					res_outcome_d = OUT_LEFT;
					res_total_d   = new_total;
					res_venues_d  = new_nv;
				end
			end
		end else if (found) begin
			act_d         = ACT_WRITE;
			res_outcome_d = OUT_UPDATED;
			new_total     = old_total - TOTAL_W'(sq[at[SIW-1:0]]) + TOTAL_W'(qty_q);
			nsq[at[SIW-1:0]] = qty_q;
			res_total_d   = new_total;
			res_venues_d  = nv;
		end else if (nv >= VW'(MAX_VENUES)) begin
			res_outcome_d = OUT_VENUE_FULL;
			res_total_d   = old_total;
			res_venues_d  = nv;
		end else begin
			act_d   = ACT_WRITE;
			new_total = old_total + TOTAL_W'(qty_q);
			new_nv    = nv + 1'b1;
			// open a slot in venue order
			for (int i = 1; i < MAX_VENUES; i++) begin
				if (VW'(i) > pos) begin
					nsv[i] = sv[i-1];
					nsq[i] = sq[i-1];
				end
			end
			nsv[pos[SIW-1:0]] = venue_q;
			nsq[pos[SIW-1:0]] = qty_q;
			res_outcome_d = OUT_JOINED;
			res_total_d   = new_total;
			res_venues_d  = new_nv;
		end

		new_row_d = '0;
		new_row_d[PRICE_W-1:0]        = price_q;
		new_row_d[TOT_LO +: TOTAL_W]  = new_total;
		new_row_d[NV_LO +: VW]        = new_nv;
		for (int i = 0; i < MAX_VENUES; i++) begin
			new_row_d[SH_LO + i*SH_W +: VENUE_W]         = nsv[i];
			new_row_d[SH_LO + i*SH_W + VENUE_W +: QTY_W] = nsq[i];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (accept) state_d = ST_SEARCH;
			ST_SEARCH:  state_d = search_more ? ST_COMPARE : ST_DECIDE;
			ST_COMPARE: state_d = ST_SEARCH;
			ST_DECIDE: begin
				unique case (act_d)
					ACT_NONE:   state_d = ST_DONE;
					ACT_WRITE:  state_d = ST_WRITE;
					ACT_INSERT: state_d = ST_SHIFT;
					ACT_ERASE:  state_d = ST_SHIFT;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_SHIFT: begin
				if (!shift_done)
					state_d = ST_MOVE;
				else if (act_q == ACT_INSERT)
					state_d = ST_WRITE;
				else
					state_d = ST_DONE;
			end
			ST_MOVE:  state_d = ST_SHIFT;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		s_axis_tready = 1'b0;
		mem_re        = 1'b0;
		mem_we        = 1'b0;
		raddr         = {side_q, mid[AW-1:0]};
		waddr         = {side_q, ptr_q[AW-1:0]};
		wdata         = rdata_q;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_SEARCH: begin
				mem_re = search_more || (lo_q < cnt_q);
				raddr  = search_more ? {side_q, mid[AW-1:0]} : {side_q, lo_q[AW-1:0]};
			end
			ST_SHIFT: begin
				mem_re = !shift_done;
				raddr  = (act_q == ACT_INSERT) ? {side_q, AW'(ptr_q - 1'b1)}
				                               : {side_q, AW'(ptr_q + 1'b1)};
			end
			ST_MOVE: mem_we = 1'b1;
			ST_WRITE: begin
				mem_we = 1'b1;
				waddr  = {side_q, lo_q[AW-1:0]};
				wdata  = new_row_q;
			end
			ST_COMPARE, ST_DECIDE, ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rdata_q <= mem[raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_bid_q <= '0;
			cnt_ask_q <= '0;
			m_valid_q <= 1'b0;
			act_q     <= ACT_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			if (state_q == ST_DECIDE) begin
				act_q <= act_d;
				if (act_d == ACT_INSERT) begin
					if (side_q) cnt_ask_q <= cnt_q + 1'b1;
					else        cnt_bid_q <= cnt_q + 1'b1;
				end else if (act_d == ACT_ERASE) begin
					if (side_q) cnt_ask_q <= cnt_q - 1'b1;
					else        cnt_bid_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			side_q  <= s_axis_tuser;
			venue_q <= s_axis_tdata[VENUE_W-1:0];
			price_q <= s_axis_tdata[VENUE_W +: PRICE_W];
			qty_q   <= s_axis_tdata[VENUE_W + PRICE_W +: QTY_W];
			cnt_q   <= s_axis_tuser ? cnt_ask_q : cnt_bid_q;
			lo_q    <= '0;
			hi_q    <= s_axis_tuser ? cnt_ask_q : cnt_bid_q;
		end
		if (state_q == ST_SEARCH)
			row_ok_q <= lo_q < cnt_q;
		if (state_q == ST_COMPARE) begin
			if (ahead) lo_q <= mid + 1'b1;
			else       hi_q <= mid;
		end
		if (state_q == ST_DECIDE) begin
			new_row_q     <= new_row_d;
			res_outcome_q <= res_outcome_d;
			res_total_q   <= res_total_d;
			res_venues_q  <= res_venues_d;
			res_shifted_q <= res_shifted_d;
			ptr_q         <= (act_d == ACT_INSERT) ? cnt_q : lo_q;
		end
		// step the move pointer once the row lands
		if (state_q == ST_MOVE)
			ptr_q <= (act_q == ACT_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
		if (state_q == ST_DONE && out_free)
			m_data_q <= {res_shifted_q, res_venues_q, res_total_q, lo_q, res_outcome_q};
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'(m_data_q);

endmodule

### hw/rtl/cobu_checker.sv
// Port-level checks for the consolidated order book update core, bound to the top level.
module cobu_checker #(
	parameter int LEVEL_DEPTH = 2048,
	parameter int MAX_VENUES  = 8,
	localparam int IW      = $clog2(LEVEL_DEPTH + 1),
	localparam int VW      = $clog2(MAX_VENUES + 1),
	localparam int OUT_RAW = cobu_pkg::OUTCOME_W + IW + cobu_pkg::TOTAL_W + VW + IW,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [OUT_W-1:0]               m_axis_tdata
);
	import cobu_pkg::*;

	localparam int VEN_LO = OUTCOME_W + IW + TOTAL_W;

	logic [OUTCOME_W-1:0] oc;
	logic [VW-1:0]        ven;
	assign oc  = m_axis_tdata[OUTCOME_W-1:0];
	assign ven = m_axis_tdata[VEN_LO +: VW];

	// a stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one word in flight: no back-to-back accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted while busy");

	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> oc <= OUT_SIDE_FULL)
		else $error("outcome out of range");

	a_insert_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (oc == OUT_INSERTED) |-> ven == VW'(1))
		else $error("inserted level without exactly one venue");

endmodule

bind consolidated_order_book_update_core cobu_checker #(
	.LEVEL_DEPTH(LEVEL_DEPTH),
	.MAX_VENUES (MAX_VENUES)
) u_cobu_checker (.*);
